FILE: hdl/median_filter_window_unit_defines.svh
// ----------------------------------------------------------------------------
// Median filter window unit: assertion macros
// Shared concurrent check forms for the median filter window unit modules.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_WINDOW_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_WINDOW_UNIT_DEFINES_SVH

// Check on every clock edge outside reset.
`define MFW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define MFW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: hdl/mfw_pkg.sv
// ----------------------------------------------------------------------------
// mfw_pkg
// Window geometry, field widths, register codes and shared types for the
// median filter window unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfw_pkg;

    // Window and frame geometry
    localparam int WIN_W      = 3;
    localparam int WIN_H      = 3;
    localparam int WIN_N      = WIN_W * WIN_H;
    localparam int MED_IDX    = WIN_N / 2;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field widths
    localparam int PIX_W = 16;
    localparam int CRD_W = 10;
    localparam int CFG_W = 11;

    // Internal widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int WD_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int HT_W   = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);
    localparam int RANK_W = $clog2(WIN_N);

    // Centre offsets from the newest window corner
    localparam int ROW_OFS = (WIN_H - 1) - (WIN_H / 2);
    localparam int COL_OFS = (WIN_W - 1) - (WIN_W / 2);

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(372);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(372);

    typedef logic [PIX_W-1:0]            t_pix;
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    // Position of one beat in the frame, from the scan counters
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             emit;
    } t_pos;

    // Side data that travels with a median
    typedef struct packed {
        logic [CRD_W-1:0] crow;
        logic [CRD_W-1:0] ccol;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/median_filter_window_unit.sv
// Path: an accepted beat passes the line memory read register, the window stage
// and the result register on its way to o_out_valid. Throughput: one pixel per
// cycle while i_out_ready stays high; each of these registers holds one beat.
// Reset: clears the scan counters, the window and the pipeline valids, and sets
// both frame size registers to 372; the line memories are not cleared.
// ----------------------------------------------------------------------------
// median_filter_window_unit
// Streaming 3x3 median filter: raster pixels in, one median per full window
// out, with centre coordinates and an end-of-frame flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_window_unit_defines.svh"

module median_filter_window_unit
    import mfw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // Pixel channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [PIX_W-1:0]     i_pixel_value,
    input  wire logic                 i_frame_start,
    // Result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [PIX_W-1:0]          o_median_value,
    output logic [CRD_W-1:0]          o_center_row,
    output logic [CRD_W-1:0]          o_center_col,
    output logic                      o_frame_last
);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             accept;
    t_pos             pos;
    logic             s2_valid;
    t_win             win;
    t_res             s2_res;
    logic             s3_ready;
    t_res             out_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
            endcase
        end
    end

    assign accept = i_in_valid && o_in_ready;

    mfw_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_frame_start  (i_frame_start),
        .i_accept       (accept),
        .o_pos          (pos)
    );

    mfw_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_pix      (i_pixel_value),
        .i_pos      (pos),
        .i_s3_ready (s3_ready),
        .o_s1_free  (o_in_ready),
        .o_valid    (s2_valid),
        .o_win      (win),
        .o_res      (s2_res)
    );

    mfw_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .i_win    (win),
        .i_res    (s2_res),
        .i_take   (i_out_ready),
        .o_ready  (s3_ready),
        .o_valid  (o_out_valid),
        .o_median (o_median_value),
        .o_res    (out_res)
    );

    assign o_center_row = out_res.crow;
    assign o_center_col = out_res.ccol;
    assign o_frame_last = out_res.last;

    `MFW_ASSERT(a_ready_when_empty, !o_out_valid |-> o_in_ready, "input stalled with an empty result register")

endmodule

`default_nettype wire

FILE: hdl/mfw_line_ram.sv
// ----------------------------------------------------------------------------
// mfw_line_ram
// Simple dual-port line memory: one write port, one read port with a
// registered read and a read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfw_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mfw_scan.sv
// ----------------------------------------------------------------------------
// mfw_scan
// Raster position counters: place each accepted beat in the frame, flag
// the last pixel and whether a full window ends at it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_window_unit_defines.svh"

module mfw_scan
    import mfw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_frame_width,
    input  wire logic [CFG_W-1:0] i_frame_height,
    input  wire logic             i_frame_start,
    input  wire logic             i_accept,
    output t_pos                  o_pos
);

    logic [CNT_W-1:0] r_col_count;
    logic [ROW_W-1:0] r_row_count;
    logic [CNT_W-1:0] n_col_count;
    logic [ROW_W-1:0] n_row_count;

    logic [WD_W-1:0] ew;
    logic [HT_W-1:0] eh;
    logic [WD_W-1:0] cs;
    logic [WD_W-1:0] c;
    logic [HT_W-1:0] rs;
    logic [HT_W-1:0] r1;
    logic [HT_W-1:0] r;
    logic            last;

    // Clamp the frame size registers
    always_comb begin
        if (i_frame_width == '0) begin
            ew = WD_W'(1);
        end else if (WD_W'(i_frame_width) > WD_W'(MAX_WIDTH)) begin
            ew = WD_W'(MAX_WIDTH);
        end else begin
            ew = WD_W'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            eh = HT_W'(1);
        end else if (HT_W'(i_frame_height) > HT_W'(MAX_HEIGHT)) begin
            eh = HT_W'(MAX_HEIGHT);
        end else begin
            eh = HT_W'(i_frame_height);
        end
    end

    // Resolve the position of this beat: frame start, line end, frame wrap
    always_comb begin
        cs = i_frame_start ? '0 : WD_W'(r_col_count);
        rs = i_frame_start ? '0 : HT_W'(r_row_count);
        if (cs >= ew) begin
            c  = '0;
            r1 = rs + HT_W'(1);
        end else begin
            c  = cs;
            r1 = rs;
        end
        r    = (r1 >= eh) ? '0 : r1;
        last = (r + HT_W'(1) == eh) && (c + WD_W'(1) == ew);

        o_pos.col  = COL_W'(c);
        o_pos.row  = ROW_W'(r);
        o_pos.last = last;
        o_pos.emit = (r >= HT_W'(WIN_H - 1)) && (c >= WD_W'(WIN_W - 1));

        n_col_count = last ? '0 : CNT_W'(c + WD_W'(1));
        n_row_count = last ? '0 : ROW_W'(r);
    end

    // Advance the counters on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (i_accept) begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
        end
    end

    `MFW_ASSERT(a_last_wraps, (i_accept && o_pos.last) |=> (r_col_count == '0 && r_row_count == '0), "counters did not wrap after the last pixel")

endmodule

`default_nettype wire

FILE: hdl/mfw_window.sv
// ----------------------------------------------------------------------------
// mfw_window
// Line buffers and sliding window: read the column above the pixel from
// the line memories, rotate the lines and shift the column into the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_window_unit_defines.svh"

module mfw_window
    import mfw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_pix i_pix,
    input  wire t_pos i_pos,
    input  wire logic i_s3_ready,
    output logic      o_s1_free,
    output logic      o_valid,
    output t_win      o_win,
    output t_res      o_res
);

    // Pixel stage
    logic r_s1_valid;
    t_pix r_s1_pix;
    t_pos r_s1_pos;
    logic s1_move;

    // Line memory read side
    t_pix rd_data    [WIN_H-1];
    t_pix r_byp_data [WIN_H-1];
    logic r_byp_hit;
    t_pix wr_data    [WIN_H-1];
    t_pix column     [WIN_H];

    // Window stage
    t_pix r_win [WIN_H][WIN_W];
    logic r_s2_valid;
    t_res r_s2_res;

    assign s1_move   = r_s1_valid && (!r_s2_valid || i_s3_ready);
    assign o_s1_free = !r_s1_valid || s1_move;

    // Hold the beat while its line data is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s1_free) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pix <= i_pix;
            r_s1_pos <= i_pos;
        end
    end

    // New column: oldest line on top, current pixel at the bottom
    always_comb begin
        for (int l = 0; l < WIN_H - 1; l++) begin
            column[l] = r_byp_hit ? r_byp_data[l] : rd_data[l];
        end
        column[WIN_H-1] = r_s1_pix;
        for (int l = 0; l < WIN_H - 1; l++) begin
            wr_data[l] = column[l + 1];
        end
    end

    // Line memories, written back as the beat leaves the pixel stage
    for (genvar l = 0; l < WIN_H - 1; l++) begin : g_line
        mfw_line_ram #(
            .DEPTH (MAX_WIDTH),
            .WIDTH (PIX_W)
        ) u_line_ram (
            .i_clk     (i_clk),
            .i_rd_en   (i_accept),
            .i_rd_addr (i_pos.col),
            .o_rd_data (rd_data[l]),
            .i_wr_en   (s1_move),
            .i_wr_addr (r_s1_pos.col),
            .i_wr_data (wr_data[l])
        );
    end

    // Forward a write-back that lands on the address being read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_byp_hit <= s1_move && (r_s1_pos.col == i_pos.col);
            for (int l = 0; l < WIN_H - 1; l++) begin
                r_byp_data[l] <= wr_data[l];
            end
        end
    end

    // Shift the window and hold the result side data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int i = 0; i < WIN_H; i++) begin
                for (int j = 0; j < WIN_W; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s1_move) begin
            r_s2_valid <= r_s1_pos.emit;
            for (int i = 0; i < WIN_H; i++) begin
                for (int j = 0; j < WIN_W - 1; j++) begin
                    r_win[i][j] <= r_win[i][j + 1];
                end
                r_win[i][WIN_W-1] <= column[i];
            end
        end else if (i_s3_ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_res.crow <= CRD_W'(r_s1_pos.row - ROW_W'(ROW_OFS));
            r_s2_res.ccol <= CRD_W'(r_s1_pos.col - COL_W'(COL_OFS));
            r_s2_res.last <= r_s1_pos.last;
        end
    end

    // Flatten the window, row by row
    always_comb begin
        for (int i = 0; i < WIN_H; i++) begin
            for (int j = 0; j < WIN_W; j++) begin
                o_win[i * WIN_W + j] = r_win[i][j];
            end
        end
    end

    assign o_valid = r_s2_valid;
    assign o_res   = r_s2_res;

    `MFW_ASSERT(a_s2_holds, (r_s2_valid && !i_s3_ready) |=> r_s2_valid, "window result dropped while stalled")

endmodule

`default_nettype wire

FILE: hdl/mfw_median.sv
// ----------------------------------------------------------------------------
// mfw_median
// Median select and result register: rank every window entry by parallel
// compares and register the entry whose rank is the middle one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_window_unit_defines.svh"

module mfw_median
    import mfw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_win i_win,
    input  wire t_res i_res,
    input  wire logic i_take,
    output logic      o_ready,
    output logic      o_valid,
    output t_pix      o_median,
    output t_res      o_res
);

    logic [RANK_W-1:0] rank [WIN_N];
    logic [WIN_N-1:0]  sel;
    t_pix              median;
    logic              r_valid;
    t_pix              r_median;
    t_res              r_res;

    // Stable rank: smaller values, and equal values that come earlier
    always_comb begin
        median = '0;
        for (int i = 0; i < WIN_N; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WIN_N; j++) begin
                if (j < i) begin
                    if (i_win[j] <= i_win[i]) begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end else if (j > i) begin
                    if (i_win[j] < i_win[i]) begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
            sel[i] = (rank[i] == RANK_W'(MED_IDX));
            median = median | (sel[i] ? i_win[i] : '0);
        end
    end

    assign o_ready = !r_valid || i_take;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_median <= median;
            r_res    <= i_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_median = r_median;
    assign o_res    = r_res;

    // Only a full window is checked; partial windows may hold unwritten line data
    `MFW_ASSERT(a_one_median, i_valid |-> $onehot(sel), "median rank select is not one-hot")

endmodule

`default_nettype wire

FILE: tb/mfw_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_median_checker
// Watches the pixel, result and register write ports of the median filter
// window unit. Keeps its own scan position, line memory and window. Queues
// the median expected for each accepted pixel that completes a full window and
// compares every result beat with the oldest one, field by field.
// ----------------------------------------------------------------------------

module mfw_median_checker
    import mfw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [PIX_W-1:0]     i_pixel_value,
    input  wire logic                 i_frame_start,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [PIX_W-1:0]     i_median_value,
    input  wire logic [CRD_W-1:0]     i_center_row,
    input  wire logic [CRD_W-1:0]     i_center_col,
    input  wire logic                 i_frame_last,
    output int                        o_err_count,
    output int                        o_pending
);

    // Keep the log short on a badly broken block; every mismatch still counts
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        t_pix             median;
        logic [CRD_W-1:0] crow;
        logic [CRD_W-1:0] ccol;
        logic             last;
    } t_median_beat;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_pix             line_mem [WIN_H-1][MAX_WIDTH];
    t_pix             win_regs [WIN_H][WIN_W];
    int               scan_col;
    int               scan_row;
    t_median_beat     expected_medians [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_err_count < MAX_PRINTS) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        o_err_count++;
    endtask

    // Sort the window and take the middle entry
    function automatic t_pix window_median();
        t_pix vals [WIN_N];
        t_pix key;
        int   n;
        int   j;
        n = 0;
        for (int r = 0; r < WIN_H; r++) begin
            for (int c = 0; c < WIN_W; c++) begin
                vals[n] = win_regs[r][c];
                n++;
            end
        end
        for (int i = 1; i < WIN_N; i++) begin
            key = vals[i];
            j   = i - 1;
            while (j >= 0 && vals[j] > key) begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = key;
        end
        return vals[MED_IDX];
    endfunction

    // Advance the scan by one pixel and queue the median it completes, if any
    task automatic scan_pixel(input t_pix pix, input logic fs);
        int           ew;
        int           eh;
        int           r;
        int           c;
        t_pix         column [WIN_H];
        logic         last;
        t_median_beat beat;
        ew = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        eh = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        if (fs) begin
            scan_col = 0;
            scan_row = 0;
        end
        if (scan_col >= ew) begin
            scan_col = 0;
            scan_row++;
        end
        if (scan_row >= eh) begin
            scan_row = 0;
        end
        r = scan_row;
        c = scan_col;

        // New column: oldest line on top, incoming pixel at the bottom
        for (int i = 0; i < WIN_H - 1; i++) begin
            column[i] = line_mem[i][c];
        end
        column[WIN_H-1] = pix;
        for (int i = 0; i < WIN_H; i++) begin
            for (int j = 0; j < WIN_W - 1; j++) begin
                win_regs[i][j] = win_regs[i][j + 1];
            end
            win_regs[i][WIN_W-1] = column[i];
        end
        for (int i = 0; i < WIN_H - 2; i++) begin
            line_mem[i][c] = line_mem[i + 1][c];
        end
        line_mem[WIN_H-2][c] = pix;

        last = (r + 1 == eh) && (c + 1 == ew);
        if (r >= WIN_H - 1 && c >= WIN_W - 1) begin
            beat.median = window_median();
            beat.crow   = CRD_W'(r - ROW_OFS);
            beat.ccol   = CRD_W'(c - COL_OFS);
            beat.last   = last;
            expected_medians = {expected_medians, beat};
        end

        // Wrap to the top of the frame after its last pixel
        if (last) begin
            scan_col = 0;
            scan_row = 0;
        end else begin
            scan_col = c + 1;
            scan_row = r;
        end
    endtask

    task automatic check_result();
        t_median_beat want;
        if (expected_medians.size() == 0) begin
            report_mismatch($sformatf("unexpected result: median %0d row %0d col %0d last %0b",
                                      i_median_value, i_center_row, i_center_col,
                                      i_frame_last));
        end else begin
            want = expected_medians.pop_front();
            if (i_median_value !== want.median) begin
                report_mismatch($sformatf("median_value got %0d want %0d (row %0d col %0d)",
                                          i_median_value, want.median, want.crow, want.ccol));
            end
            if (i_center_row !== want.crow) begin
                report_mismatch($sformatf("center_row got %0d want %0d",
                                          i_center_row, want.crow));
            end
            if (i_center_col !== want.ccol) begin
                report_mismatch($sformatf("center_col got %0d want %0d",
                                          i_center_col, want.ccol));
            end
            if (i_frame_last !== want.last) begin
                report_mismatch($sformatf("frame_last got %0b want %0b (row %0d col %0d)",
                                          i_frame_last, want.last, want.crow, want.ccol));
            end
        end
    endtask

    // Sample all ports on the rising edge; results leave before new pixels enter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (win_regs[i, j]) win_regs[i][j] = '0;
            foreach (line_mem[i, j]) line_mem[i][j] = '0;
            scan_col = 0;
            scan_row = 0;
            expected_medians.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FRAME_WIDTH:  width_reg  = i_cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                scan_pixel(i_pixel_value, i_frame_start);
            end
        end
        o_pending = expected_medians.size();
    end

endmodule

FILE: tb/tb_median_filter_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_window_unit
// Streams raster frames of many sizes into the median filter window unit:
// a short directed run over pixel extremes, frame wrap and restart, then the
// degenerate and largest frame sizes, then random frames with random pixel
// content. Both channels idle in random bursts; the result side also holds
// off long enough to back up the input. A checker module predicts and
// compares every result beat.
// ----------------------------------------------------------------------------

module tb_median_filter_window_unit;
    import mfw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 48;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 150;

    typedef enum int {
        PIX_RANDOM,
        PIX_EXTREME,
        PIX_NARROW,
        PIX_RAMP
    } t_pix_mode;

    localparam t_pix DIR_FRAME [12] = '{
        16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
        16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
        16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001
    };

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    t_cfg_idx         cfg_index   = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data    = '0;
    logic             in_valid    = 1'b0;
    logic [PIX_W-1:0] pixel_value = '0;
    logic             frame_start = 1'b0;
    logic             out_ready   = 1'b0;

    logic             in_ready;
    logic             out_valid;
    logic [PIX_W-1:0] median_value;
    logic [CRD_W-1:0] center_row;
    logic [CRD_W-1:0] center_col;
    logic             frame_last;

    int err_count;
    int pending;
    int idle_cycles;

    bit tx_gaps       = 1'b1;
    bit rx_gaps       = 1'b1;
    bit long_hold_req = 1'b0;
    int stall_left    = 0;

    median_filter_window_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_pixel_value  (pixel_value),
        .i_frame_start  (frame_start),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_median_value (median_value),
        .o_center_row   (center_row),
        .o_center_col   (center_col),
        .o_frame_last   (frame_last)
    );

    mfw_median_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_pixel_value  (pixel_value),
        .i_frame_start  (frame_start),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_median_value (median_value),
        .i_center_row   (center_row),
        .i_center_col   (center_col),
        .i_frame_last   (frame_last),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: random stall bursts, plus one long hold on request
    always begin
        @(negedge clk);
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD - 1;
            out_ready    <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Stop the run when no beat moves on either channel for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_pix next_pixel(input t_pix_mode mode, input int k);
        case (mode)
            PIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0, 1:    return 16'h0000;
                    2:       return 16'hFFFF;
                    default: return t_pix'($urandom_range(0, 65535));
                endcase
            end
            PIX_NARROW: return t_pix'(16'h8000 + $urandom_range(0, 3));
            PIX_RAMP:   return t_pix'(k * 257);
            default:    return t_pix'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one pixel beat and hold it until accepted; starts and ends at a falling edge
    task automatic send_pixel(input t_pix pix, input logic fs);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= pix;
        frame_start <= fs;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected median, then let the pipeline empty
    task automatic drain_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One frame size, a fresh frame start, then npix pixels in raster order
    task automatic run_phase(input int w, input int h, input int npix, input t_pix_mode mode,
                             input bit hold, input bit fs_noise);
        logic fs;
        drain_idle();
        set_frame(w, h);
        if (hold) begin
            long_hold_req = 1'b1;
        end
        for (int k = 0; k < npix; k++) begin
            fs = (k == 0) || (fs_noise && $urandom_range(0, 59) == 0);
            send_pixel(next_pixel(mode, k), fs);
        end
    endtask

    initial begin
        int        random_sent;
        int        w;
        int        h;
        int        npix;
        bit        save_tx;

        // Hold reset, then release it at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: pixel extremes on a 4x3 frame, wrap into the next frame,
        // then restart mid-frame
        drain_idle();
        set_frame(4, 3);
        for (int k = 0; k < 12; k++) begin
            send_pixel(DIR_FRAME[k], k == 0);
        end
        for (int k = 0; k < 3; k++) begin
            send_pixel(t_pix'(7 + k), 1'b0);
        end
        for (int k = 0; k < 12; k++) begin
            send_pixel(t_pix'(1200 - 100 * k), k == 0);
        end

        // Degenerate sizes: zero, one and two columns or rows give no results; then a 3x3 frame of extremes
        run_phase(0, 0, 12, PIX_RANDOM, 1'b0, 1'b0);
        run_phase(1, 3, 12, PIX_RANDOM, 1'b0, 1'b0);
        run_phase(2, 5, 20, PIX_RANDOM, 1'b0, 1'b0);
        run_phase(5, 2, 20, PIX_RANDOM, 1'b0, 1'b0);
        run_phase(3, 3, 27, PIX_EXTREME, 1'b0, 1'b0);

        // Largest sizes, and values above the maximum that clamp to it
        run_phase(1024, 3, 20, PIX_RANDOM, 1'b0, 1'b0);
        run_phase(2047, 3, 20, PIX_EXTREME, 1'b0, 1'b0);
        run_phase(3, 2047, 30, PIX_NARROW, 1'b0, 1'b0);

        // Back up the pipeline: result side holds off while pixels keep coming
        save_tx = tx_gaps;
        tx_gaps = 1'b0;
        run_phase(6, 5, 90, PIX_RANDOM, 1'b1, 1'b0);
        tx_gaps = save_tx;

        // Random frames of random size and content
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            if (w < WIN_W || h < WIN_H) begin
                npix = $urandom_range(8, 30);
            end else begin
                npix = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
            end
            // Stop at the item budget
            if (npix > RANDOM_ITEMS - random_sent) begin
                npix = RANDOM_ITEMS - random_sent;
            end
            // Some phases run with no idling at all
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            run_phase(w, h, npix, t_pix_mode'($urandom_range(0, 3)), 1'b0, 1'b1);
            random_sent += npix;
        end

        // Closing stretch at full rate on both sides
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_phase(7, 6, 100, PIX_RANDOM, 1'b0, 1'b1);

        drain_idle();
        if (err_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
